[src/orc_pkg.sv]
// Shared constants, types and register indexes of the oversampled report-on-change block.
package orc_pkg;

  localparam int VALUE_W     = 24;
  localparam int FRAC_W      = 8;
  localparam int MAX_AVERAGE = 16;
  localparam int RING_AW     = $clog2(MAX_AVERAGE);
  localparam int CNT_W       = RING_AW + 1;
  localparam int SUM_W       = VALUE_W + CNT_W;
  localparam int MAG_W       = SUM_W - 1;
  localparam int DIV_CNT_W   = $clog2(MAG_W);
  localparam int TIME_W      = 32;
  localparam int PERIOD_W    = 16;
  localparam int PERIOD_MS_W = PERIOD_W + 10;
  localparam int THR_W       = 23;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 23;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD_S  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_PERIOD_S    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETAINED_MODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_MODE     = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } orc_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } orc_div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [VALUE_W-1:0] quotient;
  } orc_div_rsp_t;

endpackage

[src/orc_if.sv]
// Channel interfaces of the oversampled report-on-change block.
interface orc_in_if import orc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [TIME_W-1:0]         now_ms;
  logic                      sample_valid;
  logic signed [VALUE_W-1:0] sample_value;

  modport source (output valid, now_ms, sample_valid, sample_value, input ready);
  modport sink (input valid, now_ms, sample_valid, sample_value, output ready);
endinterface

interface orc_out_if import orc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      sample_due;
  logic                      report;
  logic                      by_timer;
  logic signed [VALUE_W-1:0] report_value;

  modport source (output valid, sample_due, report, by_timer, report_value, input ready);
  modport sink (input valid, sample_due, report, by_timer, report_value, output ready);
endinterface

interface orc_cfg_if import orc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/oversampled_report_on_change.sv]
// Top level: moving average over a sample ring with timed and change-driven reports.
//
//   channel | direction | handshake     | payload
//   cfg_if  | in        | valid / ready | index, data
//   in_if   | in        | valid / ready | now_ms, sample_valid, sample_value
//   out_if  | out       | valid / ready | sample_due, report, by_timer, report_value
//
// An item without an averaged sample goes straight from idle to done; an averaged one first passes
// the single read port of the sample ring (one entry a cycle) and the bit-serial divider.
// One request is worked on at a time; the next is taken as soon as the result sits in the
// output register. Reset is synchronous and clears the ring through per-entry valid bits.
// A stalled output holds the result; configuration writes are always taken.
module oversampled_report_on_change import orc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  orc_cfg_if.sink  cfg_if,
  orc_in_if.sink   in_if,
  orc_out_if.source out_if
);

  logic [CNT_W-1:0]          avg_cnt_r;
  logic [PERIOD_W-1:0]       smp_per_r;
  logic [PERIOD_W-1:0]       snd_per_r;
  logic [THR_W-1:0]          thr_r;
  logic                      ret_r;
  logic                      int_r;

  orc_state_t                state_r;
  logic [RING_AW-1:0]        ptr_r;
  logic [CNT_W-1:0]          fill_r;
  logic [CNT_W-1:0]          rd_cnt_r;
  logic                      rd_pend_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [VALUE_W-1:0] cur_r;
  logic signed [VALUE_W-1:0] last_r;
  logic [TIME_W-1:0]         send_dl_r;
  logic [TIME_W-1:0]         smp_dl_r;
  logic [TIME_W-1:0]         now_r;
  logic                      due_r;

  logic                      out_vld_r;
  logic                      out_due_r;
  logic                      out_rep_r;
  logic                      out_tmr_r;
  logic signed [VALUE_W-1:0] out_val_r;

  logic [VALUE_W-1:0]        ring_mem [MAX_AVERAGE];
  logic [MAX_AVERAGE-1:0]    ring_vld_r;
  logic [VALUE_W-1:0]        rd_data_r;
  logic                      rd_vld_r;

  logic                      in_acc;
  logic                      avg_on;
  logic                      wr_en;
  logic                      rd_en;
  logic                      out_free;
  logic [CNT_W-1:0]          win;
  logic [RING_AW-1:0]        ptr_eff;
  logic [CNT_W-1:0]          ptr_inc;
  logic [RING_AW-1:0]        ptr_nxt;
  logic [CNT_W-1:0]          fill_clip;
  logic [CNT_W-1:0]          fill_nxt;
  logic [PERIOD_MS_W-1:0]    smp_ms;
  logic [PERIOD_MS_W-1:0]    snd_ms;
  logic                      due;
  logic                      timer;
  logic signed [VALUE_W:0]   diff;
  logic [VALUE_W:0]          abs_diff;
  logic                      cond;
  logic                      rep;
  logic signed [VALUE_W-1:0] rep_val;
  logic signed [SUM_W-1:0]   rd_ext;
  logic                      rd_done;
  orc_div_req_t              div_req;
  orc_div_rsp_t              div_rsp;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_free     = !out_vld_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_cnt_r <= '0;
      smp_per_r <= '0;
      snd_per_r <= '0;
      thr_r     <= '0;
      ret_r     <= 1'b0;
      int_r     <= 1'b0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_AVERAGE_COUNT:    avg_cnt_r <= cfg_if.data[CNT_W-1:0];
        CFG_SAMPLE_PERIOD_S:  smp_per_r <= cfg_if.data[PERIOD_W-1:0];
        CFG_SEND_PERIOD_S:    snd_per_r <= cfg_if.data[PERIOD_W-1:0];
        CFG_CHANGE_THRESHOLD: thr_r     <= cfg_if.data[THR_W-1:0];
        CFG_RETAINED_MODE:    ret_r     <= cfg_if.data[0];
        CFG_INTEGER_MODE:     int_r     <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  assign win       = (avg_cnt_r > CNT_W'(MAX_AVERAGE)) ? CNT_W'(MAX_AVERAGE) : avg_cnt_r;
  assign ptr_eff   = ({1'b0, ptr_r} >= win) ? '0 : ptr_r;
  assign ptr_inc   = {1'b0, ptr_eff} + CNT_W'(1);
  assign ptr_nxt   = (ptr_inc >= win) ? '0 : ptr_inc[RING_AW-1:0];
  assign fill_clip = (fill_r > win) ? win : fill_r;
  assign fill_nxt  = (fill_clip < win) ? fill_clip + CNT_W'(1) : fill_clip;
  assign avg_on    = in_if.sample_valid && (avg_cnt_r != '0);
  assign wr_en     = in_acc && avg_on;

  assign smp_ms    = PERIOD_MS_W'(smp_per_r) * PERIOD_MS_W'(MS_PER_S);
  assign snd_ms    = PERIOD_MS_W'(snd_per_r) * PERIOD_MS_W'(MS_PER_S);
  assign due       = (smp_per_r != '0) && (smp_dl_r < in_if.now_ms);

  assign rd_en     = (state_r == ST_READ) && (rd_cnt_r < fill_r);
  assign rd_ext    = rd_vld_r ? SUM_W'(signed'(rd_data_r)) : '0;
  assign rd_done   = (state_r == ST_READ) && (rd_cnt_r == fill_r) && !rd_pend_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[ptr_eff] <= in_if.sample_value;
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[rd_cnt_r[RING_AW-1:0]];
      rd_vld_r  <= ring_vld_r[rd_cnt_r[RING_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
    end else if (wr_en) begin
      ring_vld_r[ptr_eff] <= 1'b1;
    end
  end

  assign div_req.start    = rd_done;
  assign div_req.dividend = sum_r;
  assign div_req.divisor  = fill_r;

  orc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign timer    = (snd_per_r != '0) && (send_dl_r < now_r);
  assign diff     = {cur_r[VALUE_W-1], cur_r} - {last_r[VALUE_W-1], last_r};
  assign abs_diff = diff[VALUE_W] ? (~diff + (VALUE_W+1)'(1)) : diff;
  assign cond     = timer || (abs_diff >= (VALUE_W+1)'(thr_r));
  assign rep      = cond && !(ret_r && (cur_r == last_r));
  assign rep_val  = int_r ? {cur_r[VALUE_W-1:FRAC_W], FRAC_W'(0)} : cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ptr_r     <= '0;
      fill_r    <= '0;
      rd_cnt_r  <= '0;
      rd_pend_r <= 1'b0;
      sum_r     <= '0;
      cur_r     <= '0;
      last_r    <= '0;
      send_dl_r <= '0;
      smp_dl_r  <= '0;
      now_r     <= '0;
      due_r     <= 1'b0;
    end else begin
      rd_pend_r <= rd_en;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            now_r <= in_if.now_ms;
            due_r <= due;
            if (due) begin
              smp_dl_r <= in_if.now_ms + TIME_W'(smp_ms);
            end
            if (avg_on) begin
              ptr_r    <= ptr_nxt;
              fill_r   <= fill_nxt;
              sum_r    <= '0;
              rd_cnt_r <= '0;
              state_r  <= ST_READ;
            end else begin
              if (in_if.sample_valid) begin
                cur_r <= in_if.sample_value;
              end
              state_r <= ST_DONE;
            end
          end
        end
        ST_READ: begin
          if (rd_en) begin
            rd_cnt_r <= rd_cnt_r + CNT_W'(1);
          end
          if (rd_pend_r) begin
            sum_r <= sum_r + rd_ext;
          end
          if (rd_done) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            cur_r   <= div_rsp.quotient;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            if (cond) begin
              send_dl_r <= now_r + TIME_W'(snd_ms);
            end
            if (rep) begin
              last_r <= cur_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_due_r <= due_r;
      out_rep_r <= rep;
      out_tmr_r <= timer;
      out_val_r <= rep ? rep_val : '0;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.sample_due   = out_due_r;
  assign out_if.report       = out_rep_r;
  assign out_if.by_timer     = out_tmr_r;
  assign out_if.report_value = out_val_r;

endmodule

[src/orc_div.sv]
// Bit-serial floor divider of the ring sum by the filled count.
module orc_div import orc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  orc_div_req_t req,
  output orc_div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     dvs_r;
  logic [MAG_W-1:0]     quo_r;
  logic [SUM_W-1:0]     mag;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       trial_sub;
  logic                 q_bit;
  logic [MAG_W-1:0]     q_adj;
  logic [MAG_W-1:0]     q_res;

  assign mag       = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : req.dividend;
  assign trial     = {rem_r, quo_r[MAG_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign q_bit     = (trial >= {1'b0, dvs_r});
  assign q_adj     = quo_r + MAG_W'(neg_r && (rem_r != '0));
  assign q_res     = neg_r ? (~q_adj + MAG_W'(1)) : q_adj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == DIV_CNT_W'(MAG_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.dividend[SUM_W-1];
      quo_r <= mag[MAG_W-1:0];
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[MAG_W-2:0], q_bit};
      rem_r <= q_bit ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_res[VALUE_W-1:0];

endmodule

[test/tb_oversampled_report_on_change.sv]
// Testbench of the report-on-change block: directed and random readings against a predictor.
module tb_oversampled_report_on_change;
  import orc_pkg::*;

  localparam int CYCLE_LIMIT      = 600000;
  localparam int CHOKE_CYCLES     = 200;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int RANDOM_PHASES    = 11;
  localparam int PHASE_READINGS   = 150;

  typedef struct packed {
    logic [TIME_W-1:0]         now_ms;
    logic                      sample_valid;
    logic signed [VALUE_W-1:0] sample_value;
  } reading_t;

  typedef struct packed {
    logic                      sample_due;
    logic                      report;
    logic                      by_timer;
    logic signed [VALUE_W-1:0] report_value;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  orc_cfg_if cfg_if ();
  orc_in_if  in_if ();
  orc_out_if out_if ();

  oversampled_report_on_change u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copies and filter state of the model.
  logic [4:0]           avg_count;
  logic [PERIOD_W-1:0]  sample_period;
  logic [PERIOD_W-1:0]  send_period;
  logic [THR_W-1:0]     threshold;
  logic                 retained;
  logic                 integer_mode;
  longint               window [MAX_AVERAGE];
  int unsigned          ring_ptr;
  int unsigned          fill;
  longint               smoothed;
  longint               last_sent;
  logic [TIME_W-1:0]    send_dl;
  logic [TIME_W-1:0]    sample_dl;

  reading_t    reading_queue [$];
  verdict_t    due_verdicts [$];
  reading_t    offer = '0;
  logic        offering = 1'b0;
  logic        in_took = 1'b0;
  logic        out_took = 1'b0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_wait = 0;
  int unsigned recv_calm = 0;
  int unsigned choke_left = 0;
  int unsigned chokes_done = 0;
  int unsigned readings_taken = 0;
  int unsigned fault_count = 0;
  int unsigned cycles_run = 0;
  logic [TIME_W-1:0] clock_ms = '0;
  int          drift = 0;

  function automatic void filter_clear();
    avg_count     = '0;
    sample_period = '0;
    send_period   = '0;
    threshold     = '0;
    retained      = 1'b0;
    integer_mode  = 1'b0;
    foreach (window[i]) window[i] = 0;
    ring_ptr  = 0;
    fill      = 0;
    smoothed  = 0;
    last_sent = 0;
    send_dl   = '0;
    sample_dl = '0;
  endfunction

  function automatic void store_setting(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_AVERAGE_COUNT:    avg_count = val[4:0];
      CFG_SAMPLE_PERIOD_S:  sample_period = val[PERIOD_W-1:0];
      CFG_SEND_PERIOD_S:    send_period = val[PERIOD_W-1:0];
      CFG_CHANGE_THRESHOLD: threshold = val[THR_W-1:0];
      CFG_RETAINED_MODE:    retained = val[0];
      CFG_INTEGER_MODE:     integer_mode = val[0];
      default: ;
    endcase
  endfunction

  function automatic verdict_t filter_reading(reading_t r);
    verdict_t          v;
    int unsigned       win;
    longint            acc;
    longint            q;
    longint            change;
    logic              fire;
    logic [VALUE_W-1:0] shown;
    v = '0;
    fire = 1'b0;
    if (sample_period != 0 && sample_dl < r.now_ms) begin
      sample_dl = r.now_ms + 32'(sample_period) * 32'(MS_PER_S);
      v.sample_due = 1'b1;
    end
    if (r.sample_valid) begin
      if (avg_count != 0) begin
        win = 32'(avg_count);
        if (win > MAX_AVERAGE) win = MAX_AVERAGE;
        if (ring_ptr >= win) ring_ptr = 0;
        window[ring_ptr[RING_AW-1:0]] = longint'($signed(r.sample_value));
        ring_ptr++;
        if (ring_ptr >= win) ring_ptr = 0;
        if (fill > win) fill = win;
        if (fill < win) fill++;
        acc = 0;
        for (int unsigned i = 0; i < fill; i++) acc += window[i[RING_AW-1:0]];
        q = acc / longint'(fill);
        if ((acc % longint'(fill)) != 0 && acc < 0) q--;
        smoothed = q;
      end else begin
        smoothed = longint'($signed(r.sample_value));
      end
    end
    if (send_period != 0 && send_dl < r.now_ms) begin
      v.by_timer = 1'b1;
      fire = 1'b1;
    end else begin
      change = smoothed - last_sent;
      if (change < 0) change = -change;
      if (change >= longint'(threshold)) fire = 1'b1;
    end
    if (fire) send_dl = r.now_ms + 32'(send_period) * 32'(MS_PER_S);
    if (fire && !(retained && last_sent == smoothed)) begin
      shown = smoothed[VALUE_W-1:0];
      if (integer_mode) shown[FRAC_W-1:0] = '0;
      v.report = 1'b1;
      v.report_value = shown;
      last_sent = smoothed;
    end
    return v;
  endfunction

  function automatic void note_fault(string what, verdict_t want, verdict_t got);
    fault_count++;
    if (fault_count <= SHOWN_MISMATCHES)
      $display("%0t %s: expected due=%0b report=%0b timer=%0b value=%h, %s",
               $time, what, want.sample_due, want.report, want.by_timer, want.report_value,
               $sformatf("got due=%0b report=%0b timer=%0b value=%h",
                         got.sample_due, got.report, got.by_timer, got.report_value));
  endfunction

  function automatic int unsigned draw_pause(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  function automatic void queue_reading(logic [TIME_W-1:0] t, logic sv,
                                        logic signed [VALUE_W-1:0] val);
    reading_t r;
    r.now_ms = t;
    r.sample_valid = sv;
    r.sample_value = val;
    reading_queue.push_back(r);
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    store_setting(idx, val);
    @(negedge clk);
  endtask

  task automatic set_registers(input int unsigned avg, input int unsigned per_s,
                               input int unsigned send_s, input int unsigned thr,
                               input int unsigned ret, input int unsigned intm);
    write_register(CFG_AVERAGE_COUNT, CFG_DATA_W'(avg));
    write_register(CFG_SAMPLE_PERIOD_S, CFG_DATA_W'(per_s));
    write_register(CFG_SEND_PERIOD_S, CFG_DATA_W'(send_s));
    write_register(CFG_CHANGE_THRESHOLD, CFG_DATA_W'(thr));
    write_register(CFG_RETAINED_MODE, CFG_DATA_W'(ret));
    write_register(CFG_INTEGER_MODE, CFG_DATA_W'(intm));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    while (reading_queue.size() != 0 || offering || due_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Request driver.
  always @(negedge clk) begin
    if (rst_n) begin
      if (offering && in_took) offering = 1'b0;
      if (!offering) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (reading_queue.size() != 0) begin
          offer = reading_queue.pop_front();
          offering = 1'b1;
          send_gap = draw_pause(send_calm);
        end
      end
      in_if.valid        <= offering;
      in_if.now_ms       <= offer.now_ms;
      in_if.sample_valid <= offer.sample_valid;
      in_if.sample_value <= offer.sample_value;
    end
  end

  // Result receiver.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) recv_wait = draw_pause(recv_calm);
      if (choke_left != 0) begin
        out_if.ready <= 1'b0;
      end else if (recv_wait != 0 && out_if.valid) begin
        recv_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off while requests keep coming, so the block backs up.
  always @(posedge clk) begin
    if (choke_left != 0) begin
      choke_left <= choke_left - 1;
    end else if (rst_n && in_if.valid && in_if.ready && chokes_done < 2 &&
                 readings_taken >= 400 * (chokes_done + 1) && reading_queue.size() > 8) begin
      choke_left  <= CHOKE_CYCLES;
      chokes_done <= chokes_done + 1;
    end
  end

  always @(posedge clk) begin : sample_side
    reading_t r;
    verdict_t got;
    verdict_t want;
    in_took  <= rst_n && in_if.valid && in_if.ready;
    out_took <= rst_n && out_if.valid && out_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      r.now_ms = in_if.now_ms;
      r.sample_valid = in_if.sample_valid;
      r.sample_value = in_if.sample_value;
      due_verdicts.push_back(filter_reading(r));
      readings_taken <= readings_taken + 1;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      got.sample_due   = out_if.sample_due;
      got.report       = out_if.report;
      got.by_timer     = out_if.by_timer;
      got.report_value = out_if.report_value;
      if (due_verdicts.size() == 0) begin
        note_fault("unexpected result", '0, got);
      end else begin
        want = due_verdicts.pop_front();
        if (got.sample_due !== want.sample_due || got.report !== want.report ||
            got.by_timer !== want.by_timer || got.report_value !== want.report_value)
          note_fault("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned avg;
    int unsigned per_s;
    int unsigned send_s;
    int unsigned thr;
    logic [31:0] raw;
    logic signed [VALUE_W-1:0] val;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    in_if.valid        = 1'b0;
    in_if.now_ms       = '0;
    in_if.sample_valid = 1'b0;
    in_if.sample_value = '0;
    out_if.ready       = 1'b0;
    filter_clear();
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Averaging over four samples with both timers running, plus time wrap.
    set_registers(4, 2, 3, 23'h000100, 0, 0);
    queue_reading(32'd0, 1'b1, 24'sh000100);
    queue_reading(32'd1, 1'b1, 24'sh7FFFFF);
    queue_reading(32'd2, 1'b1, 24'sh800000);
    queue_reading(32'd3, 1'b0, 24'sh5A5A5A);
    queue_reading(32'd2500, 1'b1, 24'shFFFFFF);
    queue_reading(32'd2600, 1'b1, 24'shFFFFFF);
    queue_reading(32'd2700, 1'b1, 24'shFFFFFF);
    queue_reading(32'd2800, 1'b1, 24'shFFFFFF);
    queue_reading(32'd2900, 1'b1, 24'shFFFFFF);
    queue_reading(32'd3000, 1'b0, 24'sh000000);
    queue_reading(32'd9000, 1'b1, 24'sh000300);
    queue_reading(32'd9001, 1'b1, 24'sh000300);
    queue_reading(32'hFFFFFFFF, 1'b1, 24'sh123456);
    queue_reading(32'd0, 1'b1, 24'sh123456);
    queue_reading(32'd5000, 1'b1, 24'shEDCBAA);
    settle();

    // Raw pass-through with zero threshold, retained and integer modes.
    set_registers(0, 0, 0, 0, 1, 1);
    queue_reading(32'd10, 1'b1, 24'shFFFF80);
    queue_reading(32'd11, 1'b1, 24'shFFFF80);
    queue_reading(32'd12, 1'b0, 24'sh000000);
    queue_reading(32'd13, 1'b1, 24'sh0001FF);
    queue_reading(32'd14, 1'b1, 24'sh7FFFFF);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_registers(16, 65535, 65535, 23'h7FFFFF, 0, 1);
        1: set_registers(31, 1, 1, 0, 1, 0);
        default: begin
          pick = $urandom_range(0, 9);
          avg = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 16 :
                (pick == 3) ? 31 : $urandom_range(2, 16);
          per_s = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 5);
          send_s = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 5);
          pick = $urandom_range(0, 7);
          thr = (pick == 0) ? 0 : (pick == 1) ? 23'h7FFFFF :
                (pick == 2) ? $urandom_range(0, 23'h7FFFFF) : $urandom_range(1, 23'h600);
          set_registers(avg, per_s, send_s, thr, $urandom_range(0, 1), $urandom_range(0, 1));
        end
      endcase
      for (int k = 0; k < PHASE_READINGS; k++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) clock_ms = $urandom;
        else if (pick == 2) clock_ms = 32'hFFFFFFFF - $urandom_range(0, 3000);
        else if (pick != 1) clock_ms = clock_ms + $urandom_range(1, 1500);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          raw = $urandom;
          val = raw[VALUE_W-1:0];
          drift = int'(val);
        end else if (pick == 1) begin
          val = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
          drift = int'(val);
        end else begin
          drift = drift + int'($urandom_range(0, 2048)) - 1024;
          if (drift > 8388607) drift = 8388607;
          if (drift < -8388608) drift = -8388608;
          val = drift[VALUE_W-1:0];
        end
        queue_reading(clock_ms, $urandom_range(0, 4) != 0, val);
      end
      settle();
    end

    repeat (60) @(negedge clk);
    if (fault_count == 0 && due_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/orc_pkg.sv
src/orc_if.sv
src/orc_div.sv
src/oversampled_report_on_change.sv
test/tb_oversampled_report_on_change.sv
